// File: design/lrt_pkg.sv
// Shared types, constants and segment table for the lane race timer.
package lrt_pkg;

   // Event codes carried in the op field
   typedef enum logic [2:0] {
      OP_TICK    = 3'd0,
      OP_EDGE    = 3'd1,
      OP_NEW_RUN = 3'd2,
      OP_START   = 3'd3,
      OP_STOP    = 3'd4,
      OP_SET_POS = 3'd5
   } op_type;

   // Configuration register indexes
   localparam logic [1:0] CSR_MIN_RUN       = 2'd0;
   localparam logic [1:0] CSR_DISPLAY_DELAY = 2'd1;
   localparam logic [1:0] CSR_SHOW_FINISH   = 2'd2;

   // What the time display currently shows
   typedef enum logic [1:0] {
      TMODE_DASHES = 2'd0,
      TMODE_FAIL   = 2'd1,
      TMODE_TIME   = 2'd2
   } tmode_type;

   localparam logic [31:0] SEG_DASHES = 32'h4040_4040;
   localparam logic [31:0] SEG_FAIL   = 32'h3830_7771;
   localparam logic [7:0]  SEG_COLON  = 8'h80;
   localparam logic [31:0] FAIL_TIME  = 32'd10000;
   localparam logic [15:0] MIN_RUN_RESET = 16'd1000;
   localparam logic [15:0] DELAY_RESET   = 16'd100;
   localparam logic [3:0]  TENS_MAX      = 4'd15;

   // One item's result plus the display source, handed to the encoder
   typedef struct packed {
      logic        tripped;
      logic        report_valid;
      logic [31:0] report_time;
      logic [3:0]  report_position;
      logic        report_fail;
      tmode_type   time_mode;
      logic [31:0] time_ms;
      logic        place_shown;
      logic [3:0]  place_digit;
   } lrt_snap_type;

   // Seven-segment code of one hex digit
   function automatic logic [7:0] seg_digit(input logic [3:0] d);
      logic [7:0] s;
      case (d)
         4'h0: s = 8'h3F;
         4'h1: s = 8'h06;
         4'h2: s = 8'h5B;
         4'h3: s = 8'h4F;
         4'h4: s = 8'h66;
         4'h5: s = 8'h6D;
         4'h6: s = 8'h7D;
         4'h7: s = 8'h07;
         4'h8: s = 8'h7F;
         4'h9: s = 8'h6F;
         4'hA: s = 8'h77;
         4'hB: s = 8'h7C;
         4'hC: s = 8'h39;
         4'hD: s = 8'h5E;
         4'hE: s = 8'h79;
         default: s = 8'h71;
      endcase
      return s;
   endfunction

   // Exact x / 10 for any 32-bit x: multiply by reciprocal, keep top bits
   function automatic logic [31:0] div10(input logic [31:0] x);
      logic [63:0] p;
      p = {32'd0, x} * 64'h0000_0000_CCCC_CCCD;
      return {3'd0, p[63:35]};
   endfunction

   // x * 10 by shift and add
   function automatic logic [31:0] mul10(input logic [31:0] x);
      return {x[28:0], 3'd0} + {x[30:0], 1'b0};
   endfunction

endpackage

// File: design/lrt_state.sv
// Event decode, timer state, configuration registers and per-item result.
module lrt_state (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic                  advance,
   input  logic [2:0]            op,
   input  logic                  stop_fail,
   input  logic [3:0]            position_value,
   input  logic                  csr_write,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_wdata,
   output logic                  snap_valid,
   output lrt_pkg::lrt_snap_type snap
);

   logic [15:0] min_run_ff;
   logic [15:0] delay_ff;
   logic        show_ff;

   logic [31:0] now_ff, now_in;
   logic [31:0] start_ff, start_in;
   logic        active_ff, active_in;
   logic        latch_ff, latch_in;
   logic [31:0] run_time_ff, run_time_in;
   logic [3:0]  place_ff, place_in;
   logic [31:0] stop_ff, stop_in;
   logic        pending_ff, pending_in;
   logic        pfail_ff, pfail_in;
   lrt_pkg::tmode_type tmode_ff, tmode_in;
   logic [31:0] tms_ff, tms_in;
   logic        pshown_ff, pshown_in;
   logic [3:0]  pdigit_ff, pdigit_in;

   logic                  snap_valid_ff;
   lrt_pkg::lrt_snap_type snap_ff, snap_in;

   logic [31:0] tick_now;
   logic [31:0] run_age;
   logic [31:0] stop_age;

   assign tick_now = now_ff + 32'd1;
   assign run_age  = tick_now - start_ff;
   assign stop_age = tick_now - stop_ff;

   // Next state and result of one item
   always_comb begin
      now_in      = now_ff;
      start_in    = start_ff;
      active_in   = active_ff;
      latch_in    = latch_ff;
      run_time_in = run_time_ff;
      place_in    = place_ff;
      stop_in     = stop_ff;
      pending_in  = pending_ff;
      pfail_in    = pfail_ff;
      tmode_in    = tmode_ff;
      tms_in      = tms_ff;
      pshown_in   = pshown_ff;
      pdigit_in   = pdigit_ff;
      snap_in     = '0;
      case (lrt_pkg::op_type'(op))
         lrt_pkg::OP_TICK: begin
            now_in = tick_now;
            if (latch_ff && active_ff) begin
               latch_in = 1'b0;
               snap_in.tripped = (run_age > {16'd0, min_run_ff});
            end else if (pending_ff && (stop_age > {16'd0, delay_ff})) begin
               snap_in.report_time = run_time_ff;
               if (show_ff && !pfail_ff) begin
                  tmode_in  = lrt_pkg::TMODE_TIME;
                  tms_in    = run_time_ff;
                  pshown_in = 1'b1;
                  pdigit_in = place_ff;
               end
               if (pfail_ff) begin
                  tmode_in            = lrt_pkg::TMODE_FAIL;
                  pshown_in           = 1'b0;
                  run_time_in         = lrt_pkg::FAIL_TIME;
                  snap_in.report_time = lrt_pkg::FAIL_TIME;
               end
               snap_in.report_valid    = 1'b1;
               snap_in.report_position = place_ff;
               snap_in.report_fail     = pfail_ff;
               pending_in              = 1'b0;
               pfail_in                = 1'b0;
            end
         end
         lrt_pkg::OP_EDGE: begin
            latch_in = 1'b1;
         end
         lrt_pkg::OP_NEW_RUN: begin
            run_time_in = '0;
            start_in    = '1;
            tmode_in    = lrt_pkg::TMODE_DASHES;
            pshown_in   = 1'b0;
            place_in    = '0;
         end
         lrt_pkg::OP_START: begin
            start_in  = now_ff;
            active_in = 1'b1;
         end
         lrt_pkg::OP_STOP: begin
            run_time_in = now_ff - start_ff;
            active_in   = 1'b0;
            stop_in     = now_ff;
            pending_in  = 1'b1;
            pfail_in    = stop_fail;
         end
         lrt_pkg::OP_SET_POS: begin
            place_in = position_value;
         end
         default: begin
         end
      endcase
      // Displays as they stand after this item
      snap_in.time_mode   = tmode_in;
      snap_in.time_ms     = tms_in;
      snap_in.place_shown = pshown_in;
      snap_in.place_digit = pdigit_in;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_run_ff <= lrt_pkg::MIN_RUN_RESET;
         delay_ff   <= lrt_pkg::DELAY_RESET;
         show_ff    <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index)
            lrt_pkg::CSR_MIN_RUN:       min_run_ff <= csr_wdata;
            lrt_pkg::CSR_DISPLAY_DELAY: delay_ff   <= csr_wdata;
            lrt_pkg::CSR_SHOW_FINISH:   show_ff    <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Timer state, updated on each accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff      <= '0;
         start_ff    <= '1;
         active_ff   <= 1'b0;
         latch_ff    <= 1'b0;
         run_time_ff <= '0;
         place_ff    <= '0;
         stop_ff     <= '0;
         pending_ff  <= 1'b0;
         pfail_ff    <= 1'b0;
         tmode_ff    <= lrt_pkg::TMODE_DASHES;
         pshown_ff   <= 1'b0;
      end else if (accept) begin
         now_ff      <= now_in;
         start_ff    <= start_in;
         active_ff   <= active_in;
         latch_ff    <= latch_in;
         run_time_ff <= run_time_in;
         place_ff    <= place_in;
         stop_ff     <= stop_in;
         pending_ff  <= pending_in;
         pfail_ff    <= pfail_in;
         tmode_ff    <= tmode_in;
         pshown_ff   <= pshown_in;
      end
   end

   // Display source payload
   always_ff @(posedge clock) begin
      if (accept) begin
         tms_ff    <= tms_in;
         pdigit_ff <= pdigit_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else if (advance) begin
         snap_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         snap_ff <= snap_in;
      end
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

// File: design/lrt_display_pipe.sv
// Decimal split of the run time and seven-segment encoding of both displays.
module lrt_display_pipe (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  lrt_pkg::lrt_snap_type in_snap,
   output logic                  out_valid,
   output logic                  tripped,
   output logic                  report_valid,
   output logic [31:0]           report_time,
   output logic [3:0]            report_position,
   output logic                  report_fail,
   output logic [31:0]           time_display,
   output logic [31:0]           position_display
);

   // Stage a: ms / 10
   logic                  a_valid_ff;
   lrt_pkg::lrt_snap_type a_snap_ff;
   logic [28:0]           a_q10_ff;
   // Stage b: ms / 100
   logic                  b_valid_ff;
   lrt_pkg::lrt_snap_type b_snap_ff;
   logic [28:0]           b_q10_ff;
   logic [25:0]           b_q100_ff;
   // Stage c: ms / 1000, hundredths digit
   logic                  c_valid_ff;
   lrt_pkg::lrt_snap_type c_snap_ff;
   logic [25:0]           c_q100_ff;
   logic [22:0]           c_q1000_ff;
   logic [3:0]            c_hund_ff;
   // Stage d: ms / 10000, tenths digit
   logic                  d_valid_ff;
   lrt_pkg::lrt_snap_type d_snap_ff;
   logic [22:0]           d_q1000_ff;
   logic [18:0]           d_q10000_ff;
   logic [3:0]            d_tenths_ff;
   logic [3:0]            d_hund_ff;

   logic [31:0] a_q10_in, b_q100_in, c_q1000_in, d_q10000_in;
   logic [31:0] c_hund_wide, d_tenths_wide, e_secs_wide;
   logic [3:0]  e_secs, e_tens;
   logic [7:0]  e_tens_seg;
   logic [31:0] time_disp_in, pos_disp_in;

   logic        out_valid_ff;
   logic        tripped_ff, report_valid_ff, report_fail_ff;
   logic [31:0] report_time_ff, time_display_ff, position_display_ff;
   logic [3:0]  report_position_ff;

   assign a_q10_in    = lrt_pkg::div10(in_snap.time_ms);
   assign b_q100_in   = lrt_pkg::div10({3'd0, a_q10_ff});
   assign c_q1000_in  = lrt_pkg::div10({6'd0, b_q100_ff});
   assign d_q10000_in = lrt_pkg::div10({9'd0, c_q1000_ff});

   // Remainders from two registered quotients
   assign c_hund_wide   = {3'd0, b_q10_ff} - lrt_pkg::mul10({6'd0, b_q100_ff});
   assign d_tenths_wide = {6'd0, c_q100_ff} - lrt_pkg::mul10({9'd0, c_q1000_ff});
   assign e_secs_wide   = {9'd0, d_q1000_ff} - lrt_pkg::mul10({13'd0, d_q10000_ff});
   assign e_secs        = e_secs_wide[3:0];

   // Tens of seconds saturate at F and blank when zero
   assign e_tens     = (d_q10000_ff > 19'(lrt_pkg::TENS_MAX)) ? lrt_pkg::TENS_MAX
                                                            : d_q10000_ff[3:0];
   assign e_tens_seg = (e_tens != 4'd0) ? lrt_pkg::seg_digit(e_tens) : 8'h00;

   // Segment bytes, leftmost digit in the low byte
   always_comb begin
      case (d_snap_ff.time_mode)
         lrt_pkg::TMODE_TIME: begin
            time_disp_in = {lrt_pkg::seg_digit(d_hund_ff),
                            lrt_pkg::seg_digit(d_tenths_ff),
                            lrt_pkg::seg_digit(e_secs) | lrt_pkg::SEG_COLON,
                            e_tens_seg};
         end
         lrt_pkg::TMODE_FAIL: time_disp_in = lrt_pkg::SEG_FAIL;
         default:             time_disp_in = lrt_pkg::SEG_DASHES;
      endcase
      if (d_snap_ff.place_shown) begin
         pos_disp_in = {8'h00, lrt_pkg::seg_digit(d_snap_ff.place_digit), 16'h0000};
      end else begin
         pos_disp_in = lrt_pkg::SEG_DASHES;
      end
   end

   // Stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff   <= in_valid;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff;
         d_valid_ff   <= c_valid_ff;
         out_valid_ff <= d_valid_ff;
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      if (advance) begin
         a_snap_ff   <= in_snap;
         a_q10_ff    <= a_q10_in[28:0];
         b_snap_ff   <= a_snap_ff;
         b_q10_ff    <= a_q10_ff;
         b_q100_ff   <= b_q100_in[25:0];
         c_snap_ff   <= b_snap_ff;
         c_q100_ff   <= b_q100_ff;
         c_q1000_ff  <= c_q1000_in[22:0];
         c_hund_ff   <= c_hund_wide[3:0];
         d_snap_ff   <= c_snap_ff;
         d_q1000_ff  <= c_q1000_ff;
         d_q10000_ff <= d_q10000_in[18:0];
         d_tenths_ff <= d_tenths_wide[3:0];
         d_hund_ff   <= c_hund_ff;
         tripped_ff          <= d_snap_ff.tripped;
         report_valid_ff     <= d_snap_ff.report_valid;
         report_time_ff      <= d_snap_ff.report_time;
         report_position_ff  <= d_snap_ff.report_position;
         report_fail_ff      <= d_snap_ff.report_fail;
         time_display_ff     <= time_disp_in;
         position_display_ff <= pos_disp_in;
      end
   end

   assign out_valid        = out_valid_ff;
   assign tripped          = tripped_ff;
   assign report_valid     = report_valid_ff;
   assign report_time      = report_time_ff;
   assign report_position  = report_position_ff;
   assign report_fail      = report_fail_ff;
   assign time_display     = time_display_ff;
   assign position_display = position_display_ff;

endmodule

// File: design/lane_race_timer_with_segment_display_core.sv
// Lane race timer: event state stage followed by the display encoder pipeline.
// A result passes through six register stages after the edge that accepts its item
// (state, four divide-by-ten stages, segment encode).
// Throughput: one item per cycle; the pipeline stalls as a whole only while
// a result waits at the output.
// Reset (synchronous): configuration to 1000/100/1, timer state cleared,
// displays to dashes, pipeline emptied. csr_ready is always high.
module lane_race_timer_with_segment_display_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic        req_stop_fail,
   input  logic [3:0]  req_position_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_tripped,
   output logic        rsp_report_valid,
   output logic [31:0] rsp_report_time,
   output logic [3:0]  rsp_report_position,
   output logic        rsp_report_fail,
   output logic [31:0] rsp_time_display,
   output logic [31:0] rsp_position_display,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic                  advance;
   logic                  accept;
   logic                  snap_valid;
   lrt_pkg::lrt_snap_type snap;

   // Whole pipeline moves unless the output holds an untaken result
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;
   assign csr_ready = 1'b1;

   lrt_state u_state (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .advance        (advance),
      .op             (req_op),
      .stop_fail      (req_stop_fail),
      .position_value (req_position_value),
      .csr_write      (csr_valid),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .snap_valid     (snap_valid),
      .snap           (snap)
   );

   lrt_display_pipe u_display (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .in_valid         (snap_valid),
      .in_snap          (snap),
      .out_valid        (rsp_valid),
      .tripped          (rsp_tripped),
      .report_valid     (rsp_report_valid),
      .report_time      (rsp_report_time),
      .report_position  (rsp_report_position),
      .report_fail      (rsp_report_fail),
      .time_display     (rsp_time_display),
      .position_display (rsp_position_display)
   );

endmodule

// File: design/lrt_checker.sv
// Port-level checks for the lane race timer, bound to the top level.
module lrt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_tripped,
   input logic        rsp_report_valid,
   input logic [31:0] rsp_report_time,
   input logic [3:0]  rsp_report_position,
   input logic        rsp_report_fail,
   input logic [31:0] rsp_time_display,
   input logic [31:0] rsp_position_display
);

   // Output register is empty after a reset edge
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

   // Report fields are zero on items without a report
   a_quiet_report: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_report_valid) |->
         (rsp_report_time == 32'd0 && rsp_report_position == 4'd0 && !rsp_report_fail))
      else $error("report fields set without report");

   // A failed report shows FAIL and the fixed fail time
   a_fail_report: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_report_fail) |->
         (rsp_report_valid && rsp_report_time == lrt_pkg::FAIL_TIME &&
          rsp_time_display == lrt_pkg::SEG_FAIL &&
          rsp_position_display == lrt_pkg::SEG_DASHES))
      else $error("failed report inconsistent");

   // Trip and report never come from the same tick
   a_trip_xor_report: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_tripped && rsp_report_valid))
      else $error("trip and report together");

   // A stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_time_display)
                                      && $stable(rsp_report_time)))
      else $error("stalled result changed");

endmodule

bind lane_race_timer_with_segment_display_core lrt_checker u_lrt_checker (.*);

// File: verif/lane_race_timer_with_segment_display_core_test.sv
// Self-checking testbench for the lane race timer core with its segment displays.
module lane_race_timer_with_segment_display_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   // Codes the block must ignore, and the register index that maps to nothing
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int LONG_TICKS   = 1_100;
   localparam int STOP_EVERY   = 97;

   // Seven-segment glyphs, digit 0 in the low byte
   localparam logic [127:0] GLYPHS = 128'h7179_5E39_7C77_6F7F_077D_6D66_4F5B_063F;

   typedef struct packed {
      logic        tripped;
      logic        report_valid;
      logic [31:0] report_time;
      logic [3:0]  report_position;
      logic        report_fail;
      logic [31:0] time_display;
      logic [31:0] position_display;
   } lap_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_op = lrt_pkg::OP_TICK;
   logic        req_stop_fail = 1'b0;
   logic [3:0]  req_position_value = 4'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_tripped;
   logic        rsp_report_valid;
   logic [31:0] rsp_report_time;
   logic [3:0]  rsp_report_position;
   logic        rsp_report_fail;
   logic [31:0] rsp_time_display;
   logic [31:0] rsp_position_display;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = lrt_pkg::CSR_MIN_RUN;
   logic [15:0] csr_wdata = 16'd0;

   lane_race_timer_with_segment_display_core uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_op               (req_op),
      .req_stop_fail        (req_stop_fail),
      .req_position_value   (req_position_value),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_tripped          (rsp_tripped),
      .rsp_report_valid     (rsp_report_valid),
      .rsp_report_time      (rsp_report_time),
      .rsp_report_position  (rsp_report_position),
      .rsp_report_fail      (rsp_report_fail),
      .rsp_time_display     (rsp_time_display),
      .rsp_position_display (rsp_position_display),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   always #5 clock = ~clock;

   // Timer registers as the testbench believes them
   logic [15:0] cfg_min_run;
   logic [15:0] cfg_delay;
   logic        cfg_show;

   // Timer state mirror
   logic [31:0] timer_now;
   logic [31:0] timer_start;
   logic        run_live;
   logic        edge_seen;
   logic [31:0] lap_ms;
   logic [3:0]  finish_place;
   logic [31:0] stop_ms;
   logic        report_due;
   logic        due_fail;
   logic [31:0] time_seg;
   logic [31:0] place_seg;

   lap_result_type due_results[$];

   int  mismatches     = 0;
   int  items_accepted = 0;
   int  reports_seen   = 0;
   int  failed_reports = 0;
   int  trips_seen     = 0;
   int  reg_writes     = 0;
   int  cycle_count    = 0;
   int  stall_left     = 0;
   bit  src_gap_on     = 1'b0;
   bit  sink_stall_on  = 1'b0;

   function automatic logic [7:0] glyph(input logic [3:0] d);
      return GLYPHS[{28'd0, d} * 8 +: 8];
   endfunction

   // Time display: tens (blank when zero, capped at F), seconds with colon,
   // tenths, hundredths
   function automatic logic [31:0] time_glyphs(input logic [31:0] ms);
      int unsigned tens, secs, tenths, hund;
      logic [7:0]  lead_seg;
      tens   = ms / 10000;
      secs   = (ms / 1000) % 10;
      tenths = (ms / 100) % 10;
      hund   = (ms / 10) % 10;
      if (tens > 15) tens = 15;
      lead_seg = (tens != 0) ? glyph(tens[3:0]) : 8'h00;
      return {glyph(hund[3:0]), glyph(tenths[3:0]),
              glyph(secs[3:0]) | lrt_pkg::SEG_COLON, lead_seg};
   endfunction

   function automatic void clear_timer_mirror();
      cfg_min_run  = lrt_pkg::MIN_RUN_RESET;
      cfg_delay    = lrt_pkg::DELAY_RESET;
      cfg_show     = 1'b1;
      timer_now    = 32'd0;
      timer_start  = '1;
      run_live     = 1'b0;
      edge_seen    = 1'b0;
      lap_ms       = 32'd0;
      finish_place = 4'd0;
      stop_ms      = 32'd0;
      report_due   = 1'b0;
      due_fail     = 1'b0;
      time_seg     = lrt_pkg::SEG_DASHES;
      place_seg    = lrt_pkg::SEG_DASHES;
   endfunction

   // Apply one event to the mirror and return what the block should answer
   function automatic lap_result_type step_timer(input logic [2:0] op, input logic fail,
                                                  input logic [3:0] pos);
      lap_result_type r;
      r = '0;
      case (op)
         lrt_pkg::OP_TICK: begin
            timer_now = timer_now + 32'd1;
            if (edge_seen && run_live) begin
               edge_seen = 1'b0;
               if (timer_now - timer_start > {16'd0, cfg_min_run}) r.tripped = 1'b1;
            end else if (report_due && (timer_now - stop_ms > {16'd0, cfg_delay})) begin
               if (cfg_show && !due_fail) begin
                  time_seg  = time_glyphs(lap_ms);
                  place_seg = {8'h00, glyph(finish_place), 16'h0000};
               end
               if (due_fail) begin
                  time_seg  = lrt_pkg::SEG_FAIL;
                  place_seg = lrt_pkg::SEG_DASHES;
                  lap_ms    = lrt_pkg::FAIL_TIME;
               end
               r.report_valid    = 1'b1;
               r.report_time     = lap_ms;
               r.report_position = finish_place;
               r.report_fail     = due_fail;
               report_due = 1'b0;
               due_fail   = 1'b0;
            end
         end
         lrt_pkg::OP_EDGE: edge_seen = 1'b1;
         lrt_pkg::OP_NEW_RUN: begin
            lap_ms       = 32'd0;
            timer_start  = '1;
            time_seg     = lrt_pkg::SEG_DASHES;
            place_seg    = lrt_pkg::SEG_DASHES;
            finish_place = 4'd0;
         end
         lrt_pkg::OP_START: begin
            timer_start = timer_now;
            run_live    = 1'b1;
         end
         lrt_pkg::OP_STOP: begin
            lap_ms     = timer_now - timer_start;
            run_live   = 1'b0;
            stop_ms    = timer_now;
            report_due = 1'b1;
            due_fail   = fail;
         end
         lrt_pkg::OP_SET_POS: finish_place = pos;
         default: ;
      endcase
      r.time_display     = time_seg;
      r.position_display = place_seg;
      return r;
   endfunction

   function automatic void compare_field(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
   endfunction

   // Result sink: random stall bursts
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (sink_stall_on && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 9);
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watch all three channels: predict on accepted items, check on results
   always @(posedge clock) begin
      lap_result_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            reg_writes++;
            case (csr_index)
               lrt_pkg::CSR_MIN_RUN:       cfg_min_run = csr_wdata;
               lrt_pkg::CSR_DISPLAY_DELAY: cfg_delay   = csr_wdata;
               lrt_pkg::CSR_SHOW_FINISH:   cfg_show    = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            items_accepted++;
            due_results.push_back(step_timer(req_op, req_stop_fail, req_position_value));
         end
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               mismatches++;
               $display("%0t ns: result with nothing expected, expected none, actual %0h",
                        $time, rsp_report_time);
            end else begin
               want = due_results.pop_front();
               compare_field("tripped", 32'(want.tripped), 32'(rsp_tripped));
               compare_field("report_valid", 32'(want.report_valid), 32'(rsp_report_valid));
               compare_field("report_time", want.report_time, rsp_report_time);
               compare_field("report_position", 32'(want.report_position),
                             32'(rsp_report_position));
               compare_field("report_fail", 32'(want.report_fail), 32'(rsp_report_fail));
               compare_field("time_display", want.time_display, rsp_time_display);
               compare_field("position_display", want.position_display,
                             rsp_position_display);
               if (want.tripped) trips_seen++;
               if (want.report_valid) reports_seen++;
               if (want.report_fail) failed_reports++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t ns: cycle limit reached with %0d results outstanding", $time,
                  due_results.size());
         $display("lane_race_timer_with_segment_display_core_test NOT OK");
         $finish;
      end
   end

   // Offer one item, with an occasional idle burst before it
   task automatic send_event(input logic [2:0] op, input logic fail, input logic [3:0] pos);
      int gap;
      if (src_gap_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_op             <= op;
      req_stop_fail      <= fail;
      req_position_value <= pos;
      do @(posedge clock); while (!req_ready);
   endtask

   // Don't-care fields get random values
   task automatic send_op(input logic [2:0] op);
      send_event(op, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
   endtask

   task automatic send_noise();
      send_op(3'($urandom_range(0, 7)));
   endtask

   // Hold the sender off until every outstanding result has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (due_results.size() != 0);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val, input bit last);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (last) csr_valid <= 1'b0;
   endtask

   // Full register set, plus a write to the unmapped index each time
   task automatic program_timer(input logic [15:0] min_ms, input logic [15:0] delay_ms,
                                input logic [15:0] show_word);
      write_reg(lrt_pkg::CSR_MIN_RUN, min_ms, 1'b0);
      write_reg(lrt_pkg::CSR_DISPLAY_DELAY, delay_ms, 1'b0);
      write_reg(CSR_UNUSED, 16'($urandom_range(0, 65535)), 1'b0);
      write_reg(lrt_pkg::CSR_SHOW_FINISH, show_word, 1'b1);
   endtask

   // One race: arm, start, ticks with stray edges, finish edge, stop, trailing ticks
   task automatic run_race();
      int lead, tail, pick;
      if ($urandom_range(0, 3) != 0) send_op(lrt_pkg::OP_NEW_RUN);
      if ($urandom_range(0, 1) != 0) send_op(lrt_pkg::OP_SET_POS);
      send_op(lrt_pkg::OP_START);
      lead = $urandom_range(0, int'(cfg_min_run) + 4);
      if (lead > 60) lead = 60;
      repeat (lead) begin
         pick = $urandom_range(0, 15);
         if (pick == 0) send_op(lrt_pkg::OP_EDGE);
         else if (pick == 1) send_noise();
         else if (pick == 2) send_op(lrt_pkg::OP_SET_POS);
         else send_op(lrt_pkg::OP_TICK);
      end
      send_op(lrt_pkg::OP_EDGE);
      send_op(lrt_pkg::OP_TICK);
      if ($urandom_range(0, 1) != 0) send_op(lrt_pkg::OP_SET_POS);
      send_event(lrt_pkg::OP_STOP, $urandom_range(0, 3) == 0, 4'($urandom_range(0, 15)));
      tail = $urandom_range(0, int'(cfg_delay) + 3);
      if (tail > 40) tail = 40;
      repeat (tail) begin
         if ($urandom_range(0, 11) == 0) send_noise();
         else send_op(lrt_pkg::OP_TICK);
      end
   endtask

   // Short hand-built sequence: idle codes, trip, report, failed report, latch rules
   task automatic test_directed_events();
      src_gap_on    = 1'b1;
      sink_stall_on = 1'b1;
      wait_idle();
      program_timer(16'd0, 16'd0, 16'd1);
      send_event(lrt_pkg::OP_TICK, 1'b0, 4'd0);
      send_event(OP_SPARE_A, 1'b1, 4'd15);
      send_event(OP_SPARE_B, 1'b1, 4'd15);
      send_event(lrt_pkg::OP_SET_POS, 1'b0, 4'd15);
      send_event(lrt_pkg::OP_START, 1'b0, 4'd0);
      send_event(lrt_pkg::OP_EDGE, 1'b0, 4'd0);
      // edge with run active: trip
      send_event(lrt_pkg::OP_TICK, 1'b0, 4'd0);
      send_event(lrt_pkg::OP_EDGE, 1'b0, 4'd0);
      send_event(lrt_pkg::OP_STOP, 1'b0, 4'd0);
      // latch set but no run: report goes out, latch survives
      send_event(lrt_pkg::OP_TICK, 1'b0, 4'd0);
      send_event(lrt_pkg::OP_NEW_RUN, 1'b0, 4'd0);
      send_event(lrt_pkg::OP_SET_POS, 1'b0, 4'd9);
      send_event(lrt_pkg::OP_STOP, 1'b1, 4'd0);
      // failed run shows FAIL
      send_event(lrt_pkg::OP_TICK, 1'b0, 4'd0);
      send_event(lrt_pkg::OP_START, 1'b0, 4'd0);
      // old latch now trips the new run
      send_event(lrt_pkg::OP_TICK, 1'b0, 4'd0);
   endtask

   // Register extremes, masking of the show flag, and a held-back report
   task automatic test_register_limits();
      wait_idle();
      program_timer(16'hFFFF, 16'hFFFF, 16'hFFFE);
      send_event(lrt_pkg::OP_EDGE, 1'b1, 4'd0);
      send_event(lrt_pkg::OP_TICK, 1'b0, 4'd0);
      send_event(lrt_pkg::OP_STOP, 1'b0, 4'd0);
      send_event(lrt_pkg::OP_TICK, 1'b0, 4'd0);
      send_event(lrt_pkg::OP_TICK, 1'b0, 4'd0);
      wait_idle();
      // delay dropped to zero: pending report leaves without display update
      program_timer(16'd0, 16'd0, 16'd0);
      send_event(lrt_pkg::OP_TICK, 1'b0, 4'd0);
   endtask

   // Long run with periodic stops: reports of a growing time, seconds digit past zero
   task automatic test_long_run();
      src_gap_on    = 1'b0;
      sink_stall_on = 1'b0;
      wait_idle();
      program_timer(16'd0, 16'd2, 16'd1);
      send_event(lrt_pkg::OP_NEW_RUN, 1'b0, 4'd0);
      send_event(lrt_pkg::OP_SET_POS, 1'b0, 4'd7);
      send_event(lrt_pkg::OP_START, 1'b0, 4'd0);
      for (int t = 1; t <= LONG_TICKS; t++) begin
         send_event(lrt_pkg::OP_TICK, 1'b0, 4'd0);
         if (t % STOP_EVERY == 0) send_event(lrt_pkg::OP_STOP, 1'b0, 4'd7);
      end
      repeat (4) send_event(lrt_pkg::OP_TICK, 1'b0, 4'd0);
   endtask

   // Random races under random thresholds; optional drains of the pipeline
   task automatic test_random_races(input int count, input bit pressure);
      int stop_at;
      wait_idle();
      program_timer(16'($urandom_range(0, 20)), 16'($urandom_range(0, 8)),
                    16'($urandom_range(0, 65535)));
      stop_at = items_accepted + count;
      while (items_accepted < stop_at) begin
         src_gap_on    = ($urandom_range(0, 3) != 0);
         sink_stall_on = ($urandom_range(0, 3) != 0);
         run_race();
         if (pressure && $urandom_range(0, 4) == 0) wait_idle();
      end
   endtask

   // Trip threshold out of reach, reports immediate
   task automatic test_slow_thresholds();
      int stop_at;
      wait_idle();
      program_timer(16'hFFFF, 16'd0, 16'($urandom_range(0, 65535)));
      stop_at = items_accepted + 80;
      src_gap_on    = 1'b1;
      sink_stall_on = 1'b1;
      while (items_accepted < stop_at) run_race();
   endtask

   // Closing stretch with both sides running flat out
   task automatic test_quiet_finish();
      int stop_at;
      wait_idle();
      program_timer(16'($urandom_range(0, 20)), 16'($urandom_range(0, 8)), 16'd1);
      src_gap_on    = 1'b0;
      sink_stall_on = 1'b0;
      stop_at = items_accepted + 150;
      while (items_accepted < stop_at) run_race();
   endtask

   initial begin
      clear_timer_mirror();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed_events();
      test_register_limits();
      test_long_run();
      test_random_races(200, 1'b0);
      // forced drain at least once, then random ones
      wait_idle();
      test_random_races(150, 1'b1);
      test_random_races(150, 1'b1);
      test_slow_thresholds();
      test_random_races(120, 1'b0);
      test_quiet_finish();
      wait_idle();
      repeat (20) @(posedge clock);
      $display("Covered %0d events, %0d register writes, %0d finish trips,", items_accepted,
               reg_writes, trips_seen);
      $display("%0d finish reports (%0d failed runs), %0d field mismatches", reports_seen,
               failed_reports, mismatches);
      if (mismatches == 0 && due_results.size() == 0) begin
         $display("lane_race_timer_with_segment_display_core_test OK");
      end else begin
         $display("lane_race_timer_with_segment_display_core_test NOT OK");
      end
      $finish;
   end

endmodule
